// ===== hw/rtl/sph_pkg.sv =====
// Shared types and constants of the scope path signature hasher.
package sph_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 16;

  localparam logic [63:0] FNV_BASIS    = 64'hcbf29ce484222325;
  // FNV prime 0x100000001b3 = 2^40 + 0x1b3
  localparam logic [63:0] FNV_PRIME_LO = 64'h00000000000001b3;
  localparam int unsigned FNV_PRIME_SH = 40;

  localparam logic [63:0] TAG_MATRIX = 64'h1;
  localparam logic [63:0] TAG_SPRITE = 64'h2;

  typedef enum logic [2:0] {
    CMD_OPEN   = 3'd0,
    CMD_CLOSE  = 3'd1,
    CMD_MATRIX = 3'd2,
    CMD_SPRITE = 3'd3,
    CMD_FRAME  = 3'd4
  } cmd_t;

  typedef struct packed {
    logic [63:0] hash;
    logic [31:0] mcnt;
    logic [31:0] scnt;
  } frame_t;

endpackage

// ===== hw/rtl/sph_if.sv =====
// Input and result channel interfaces.
interface sph_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] scope_key;
  logic [63:0] child_id;

  modport source (output valid, command, scope_key, child_id, input ready);
  modport sink   (input valid, command, scope_key, child_id, output ready);
endinterface

interface sph_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] signature;
  logic        signature_valid;
  logic        signature_kind;
  logic        stack_overflow;

  modport source (output valid, signature, signature_valid, signature_kind, stack_overflow,
                  input ready);
  modport sink   (input valid, signature, signature_valid, signature_kind, stack_overflow,
                  output ready);
endinterface

// ===== hw/rtl/sph_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sph_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/sph_mix_unit.sv =====
// Shared FNV-1a mixing step: y = (a ^ b) * prime mod 2^64.
module sph_mix_unit (
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] y
);
  import sph_pkg::*;

  logic [63:0] x;
  logic [63:0] lo_prod;

  assign x       = a ^ b;
  assign lo_prod = x * FNV_PRIME_LO;
  assign y       = (x << FNV_PRIME_SH) + lo_prod;

endmodule

// ===== hw/rtl/scope_path_signature_hasher_core.sv =====
// Top level of the scope path signature hasher.
//
// in_if carries one scene operation per beat (command, scope_key, child_id);
// out_if returns exactly one result beat per operation: signature,
// signature_valid, signature_kind and the sticky stack_overflow flag.
// Open, matrix and sprite operations run the top frame through the shared
// mixing unit twice (one step per cycle): ST_RD fetches the top frame,
// ST_MIX1 and ST_MIX2 mix, ST_DONE loads the result register; the next
// beat is taken only after the return to idle. Close, frame start and
// unused codes skip the mixing steps (ST_RD goes to ST_DONE). The frame
// stack sits in one RAM read at the top level; the root frame lives in flops.
// in_if.ready is high only while the sequencer is idle.
// Reset leaves only the root frame, clears the overflow flag and drops any
// pending result; the stack RAM needs no clearing since every frame above
// the root is pushed before it is read.
// A stalled receiver holds the result register; the sequencer waits with
// the next result until it is taken.
module scope_path_signature_hasher_core #(
  parameter int unsigned STACK_DEPTH = sph_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sph_in_if.sink    in_if,
  sph_out_if.source out_if
);
  import sph_pkg::*;

  localparam int unsigned LVL_W = $clog2(STACK_DEPTH);
  localparam int unsigned FRM_W = $bits(frame_t);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD   = 5'b00010,
    ST_MIX1 = 5'b00100,
    ST_MIX2 = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [31:0] root_m_r, root_m_nxt;
  logic [31:0] root_s_r, root_s_nxt;
  logic ovf_r, ovf_nxt;
  logic [2:0] cmd_r;
  logic [63:0] key_r, id_r;
  frame_t top_r, top_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [63:0] sig_r, sig_nxt;
  logic sv_r, sv_nxt;
  logic kind_r, kind_nxt;
  logic ovf_out_r, ovf_out_nxt;

  logic in_acc, out_free, is_open, is_sprite, is_sig, full;
  logic [63:0] mix_b, mix_y;
  logic ram_we;
  logic [LVL_W-1:0] ram_waddr;
  frame_t ram_wdata, ram_q;
  logic [FRM_W-1:0] ram_rdata;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign is_open     = (cmd_r == CMD_OPEN);
  assign is_sprite   = (cmd_r == CMD_SPRITE);
  assign is_sig      = (cmd_r == CMD_MATRIX) || (cmd_r == CMD_SPRITE);
  assign full        = (lvl_r == LVL_W'(STACK_DEPTH - 1));
  assign ram_q       = frame_t'(ram_rdata);

  assign out_if.valid           = out_valid_r;
  assign out_if.signature       = sig_r;
  assign out_if.signature_valid = sv_r;
  assign out_if.signature_kind  = kind_r;
  assign out_if.stack_overflow  = ovf_out_r;

  sph_ram #(
    .WIDTH(FRM_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(lvl_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    if (state_r == ST_MIX1) begin
      mix_b = is_open ? key_r : (is_sprite ? TAG_SPRITE : TAG_MATRIX);
    end else begin
      mix_b = is_open ? id_r : {32'd0, (is_sprite ? top_r.scnt : top_r.mcnt)};
    end
  end

  sph_mix_unit u_mix (
    .a(acc_r),
    .b(mix_b),
    .y(mix_y)
  );

  always_comb begin
    state_nxt     = state_r;
    lvl_nxt       = lvl_r;
    root_m_nxt    = root_m_r;
    root_s_nxt    = root_s_r;
    ovf_nxt       = ovf_r;
    top_nxt       = top_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    sig_nxt       = sig_r;
    sv_nxt        = sv_r;
    kind_nxt      = kind_r;
    ovf_out_nxt   = ovf_out_r;
    ram_we        = 1'b0;
    ram_waddr     = lvl_r;
    ram_wdata     = top_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        if (lvl_r == '0) begin
          top_nxt = '{hash: FNV_BASIS, mcnt: root_m_r, scnt: root_s_r};
        end else begin
          top_nxt = ram_q;
        end
        acc_nxt   = top_nxt.hash;
        state_nxt = (is_open || is_sig) ? ST_MIX1 : ST_DONE;
      end
      ST_MIX1: begin
        acc_nxt   = mix_y;
        state_nxt = ST_MIX2;
      end
      ST_MIX2: begin
        acc_nxt   = mix_y;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
          unique case (cmd_r)
            CMD_OPEN: begin
              if (full) begin
                ovf_nxt = 1'b1;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = lvl_r + LVL_W'(1);
                ram_wdata = '{hash: acc_r, mcnt: 32'd0, scnt: 32'd0};
                lvl_nxt   = lvl_r + LVL_W'(1);
              end
            end
            CMD_CLOSE: begin
              if (lvl_r != '0) begin
                lvl_nxt = lvl_r - LVL_W'(1);
              end
            end
            CMD_MATRIX: begin
              if (lvl_r == '0) begin
                root_m_nxt = top_r.mcnt + 32'd1;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = '{hash: top_r.hash, mcnt: top_r.mcnt + 32'd1, scnt: top_r.scnt};
              end
            end
            CMD_SPRITE: begin
              if (lvl_r == '0) begin
                root_s_nxt = top_r.scnt + 32'd1;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = '{hash: top_r.hash, mcnt: top_r.mcnt, scnt: top_r.scnt + 32'd1};
              end
            end
            CMD_FRAME: begin
              lvl_nxt    = '0;
              root_m_nxt = 32'd0;
              root_s_nxt = 32'd0;
            end
            default: begin
            end
          endcase
          out_valid_nxt = 1'b1;
          sv_nxt        = is_sig;
          kind_nxt      = is_sprite;
          sig_nxt       = is_sig ? acc_r : 64'd0;
          ovf_out_nxt   = ovf_nxt;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      lvl_r       <= '0;
      root_m_r    <= 32'd0;
      root_s_r    <= 32'd0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lvl_r       <= lvl_nxt;
      root_m_r    <= root_m_nxt;
      root_s_r    <= root_s_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r <= in_if.command;
      key_r <= in_if.scope_key;
      id_r  <= in_if.child_id;
    end
    top_r     <= top_nxt;
    acc_r     <= acc_nxt;
    sig_r     <= sig_nxt;
    sv_r      <= sv_nxt;
    kind_r    <= kind_nxt;
    ovf_out_r <= ovf_out_nxt;
  end

endmodule

// ===== hw/rtl/sph_checker.sv =====
// Port-level checker for the scope path signature hasher, bound to the top level.
module sph_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] signature,
  input logic        signature_valid,
  input logic        signature_kind
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat pending right after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted again while operation in flight");

  a_no_sig_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !signature_valid |-> signature == 64'd0 && !signature_kind)
    else $error("non-signature beat carries signature bits");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(signature))
    else $error("stalled result beat changed");

endmodule

bind scope_path_signature_hasher_core sph_checker u_sph_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_if.valid),
  .in_ready       (in_if.ready),
  .out_valid      (out_if.valid),
  .out_ready      (out_if.ready),
  .signature      (out_if.signature),
  .signature_valid(out_if.signature_valid),
  .signature_kind (out_if.signature_kind)
);

// ===== dv/sph_signature_checker.sv =====
// Scoreboard for the scope path signature hasher: predicts and checks every result beat.
module sph_signature_checker #(
  parameter int unsigned STACK_DEPTH = sph_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sph_in_if           in_mon,
  sph_out_if          out_mon,
  output int unsigned n_errors,
  output int unsigned n_pending,
  output int unsigned n_ops,
  output int unsigned n_sigs,
  output int unsigned max_level,
  output int unsigned n_dropped
);
  import sph_pkg::*;

  localparam logic [63:0] PRIME = (64'd1 << FNV_PRIME_SH) | FNV_PRIME_LO;

  typedef struct packed {
    logic [63:0] signature;
    logic        sig_valid;
    logic        sig_kind;
    logic        overflow;
  } sig_beat_t;

  frame_t      scopes [STACK_DEPTH];
  int unsigned top_lvl;
  logic        overflow;
  sig_beat_t   expected_sigs [$];
  int unsigned err_cnt   = 0;
  int unsigned op_cnt    = 0;
  int unsigned sig_cnt   = 0;
  int unsigned deepest   = 0;
  int unsigned drop_cnt  = 0;

  function automatic logic [63:0] fnv_mix(input logic [63:0] h, input logic [63:0] v);
    return (h ^ v) * PRIME;
  endfunction

  function automatic void clear_scopes();
    for (int i = 0; i < STACK_DEPTH; i++) scopes[i] = '0;
    scopes[0].hash = FNV_BASIS;
    top_lvl        = 0;
    overflow       = 1'b0;
  endfunction

  function automatic sig_beat_t apply_op(input logic [2:0] code, input logic [63:0] key,
                                         input logic [63:0] id);
    sig_beat_t   r;
    logic [63:0] h;
    r = '0;
    case (code)
      CMD_OPEN: begin
        if (top_lvl + 1 < STACK_DEPTH) begin
          h = fnv_mix(fnv_mix(scopes[top_lvl].hash, key), id);
          top_lvl++;
          scopes[top_lvl] = '{hash: h, mcnt: 32'd0, scnt: 32'd0};
        end else begin
          overflow = 1'b1;
          drop_cnt++;
        end
      end
      CMD_CLOSE: begin
        if (top_lvl > 0) top_lvl--;
      end
      CMD_MATRIX: begin
        r.signature = fnv_mix(fnv_mix(scopes[top_lvl].hash, TAG_MATRIX),
                              {32'd0, scopes[top_lvl].mcnt});
        scopes[top_lvl].mcnt = scopes[top_lvl].mcnt + 32'd1;
        r.sig_valid = 1'b1;
        r.sig_kind  = 1'b0;
      end
      CMD_SPRITE: begin
        r.signature = fnv_mix(fnv_mix(scopes[top_lvl].hash, TAG_SPRITE),
                              {32'd0, scopes[top_lvl].scnt});
        scopes[top_lvl].scnt = scopes[top_lvl].scnt + 32'd1;
        r.sig_valid = 1'b1;
        r.sig_kind  = 1'b1;
      end
      CMD_FRAME: begin
        top_lvl   = 0;
        scopes[0] = '{hash: FNV_BASIS, mcnt: 32'd0, scnt: 32'd0};
      end
      default: ;
    endcase
    r.overflow = overflow;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    sig_beat_t want;
    if (!rst_n) begin
      clear_scopes();
      expected_sigs.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_sigs.size() == 0) begin
          $error("result beat with nothing pending: signature %h", out_mon.signature);
          err_cnt++;
        end else begin
          want = expected_sigs.pop_front();
          check_field("signature", want.signature, out_mon.signature);
          check_field("signature_valid", 64'(want.sig_valid), 64'(out_mon.signature_valid));
          check_field("signature_kind", 64'(want.sig_kind), 64'(out_mon.signature_kind));
          check_field("stack_overflow", 64'(want.overflow), 64'(out_mon.stack_overflow));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = apply_op(in_mon.command, in_mon.scope_key, in_mon.child_id);
        expected_sigs = {expected_sigs, want};
        op_cnt++;
        if (want.sig_valid) sig_cnt++;
        if (top_lvl > deepest) deepest = top_lvl;
      end
    end
    n_errors  <= err_cnt;
    n_pending <= expected_sigs.size();
    n_ops     <= op_cnt;
    n_sigs    <= sig_cnt;
    max_level <= deepest;
    n_dropped <= drop_cnt;
  end

endmodule

// ===== dv/tb.sv =====
// Testbench top: clock, reset, scene operation stimulus, receiver stalls and verdict.
module tb;
  import sph_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned PHASE_OPS   = 420;
  localparam logic [2:0]  CMD_NONE_LO = 3'd5;
  localparam logic [2:0]  CMD_NONE_HI = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        hold_req = 1'b0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned sent = 0;
  int unsigned n_errors, n_pending, n_ops, n_sigs, max_level, n_dropped;

  sph_in_if  in_if ();
  sph_out_if out_if ();

  scope_path_signature_hasher_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  sph_signature_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_if),
    .out_mon   (out_if),
    .n_errors  (n_errors),
    .n_pending (n_pending),
    .n_ops     (n_ops),
    .n_sigs    (n_sigs),
    .max_level (max_level),
    .n_dropped (n_dropped)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int unsigned held;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: %0d cycles without a beat", IDLE_LIMIT);
    $display("** scope_path_signature_hasher_core: FAILED **");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_op(input logic [2:0] code, input logic [63:0] key,
                         input logic [63:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.command   <= code;
    in_if.scope_key <= key;
    in_if.child_id  <= id;
    do begin
      @(posedge clk);
    end while (!in_if.ready);
    sent++;
  endtask

  // open share varies per scene so some scenes go deep and some stay shallow
  task automatic send_random(input int unsigned open_pct);
    int unsigned pick;
    logic [2:0]  code;
    pick = $urandom_range(99);
    if (pick < open_pct)  code = CMD_OPEN;
    else if (pick < 45)   code = CMD_CLOSE;
    else if (pick < 70)   code = CMD_MATRIX;
    else if (pick < 95)   code = CMD_SPRITE;
    else if (pick < 98)   code = CMD_FRAME;
    else                  code = 3'($urandom_range(CMD_NONE_HI, CMD_NONE_LO));
    send_op(code, rand64(), rand64());
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_base;
    int unsigned open_pct;
    int unsigned len;
    in_if.valid     = 1'b0;
    in_if.command   = CMD_OPEN;
    in_if.scope_key = '0;
    in_if.child_id  = '0;
    rst_n           = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_op(CMD_MATRIX, '0, '0);
    send_op(CMD_MATRIX, '1, '1);
    send_op(CMD_SPRITE, rand64(), rand64());
    send_op(CMD_CLOSE, rand64(), rand64());
    send_op(CMD_OPEN, '0, '0);
    send_op(CMD_OPEN, '1, '1);
    send_op(CMD_MATRIX, rand64(), rand64());
    send_op(CMD_SPRITE, rand64(), rand64());
    send_op(CMD_CLOSE, rand64(), rand64());
    send_op(CMD_MATRIX, rand64(), rand64());
    send_op(CMD_FRAME, rand64(), rand64());
    send_op(CMD_MATRIX, rand64(), rand64());
    send_op(CMD_NONE_LO, rand64(), rand64());
    send_op(CMD_NONE_HI, rand64(), rand64());
    // fill the stack; the last open is dropped and sets overflow
    repeat (STACK_DEPTH_DEF) send_op(CMD_OPEN, rand64(), rand64());
    send_op(CMD_SPRITE, rand64(), rand64());

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
          hold_req       = 1'b1;
        end
        1: begin
          send_idle_pct  = 85;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 85;
        end
        default: begin
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
      endcase
      phase_base = sent;
      while (sent - phase_base < PHASE_OPS) begin
        send_op(CMD_FRAME, rand64(), rand64());
        open_pct = $urandom_range(32, 15);
        len      = $urandom_range(60, 10);
        repeat (len) send_random(open_pct);
      end
    end

    in_if.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (n_pending != 0);
    repeat (16) @(posedge clk);

    $display("checked %0d operations with %0d signatures; deepest scope %0d, %0d opens dropped",
             n_ops, n_sigs, max_level, n_dropped);
    $display("traffic: free flow, sender 85%% idle, receiver 85%% stalled, both 25%%, %0d-cycle hold",
             HOLD_CYCLES);
    if (n_errors == 0 && n_pending == 0) begin
      $display("** scope_path_signature_hasher_core: PASSED **");
    end else begin
      $display("** scope_path_signature_hasher_core: FAILED **");
    end
    $finish;
  end

endmodule
